// ===== sv/tna_pkg.sv =====
package tna_pkg;

    localparam int CoordW   = 24;
    localparam int EdgeW    = CoordW + 1;
    localparam int ProdW    = 2 * EdgeW;
    localparam int MagW     = ProdW - 1;
    localparam int MagLoW   = 25;
    localparam int MagHiW   = MagW - MagLoW;
    localparam int SumW     = 100;
    localparam int RadW     = SumW + 2;
    localparam int LenW     = RadW / 2;
    localparam int Root1W   = LenW;
    localparam int Rad2W    = 2 * ((Root1W + 1) / 2);
    localparam int Root2W   = Rad2W / 2;
    localparam int QuotW    = 15;
    localparam int NumW     = MagW + QuotW + 1;
    localparam int DivW     = LenW + 1;
    localparam int AreaW    = 32;
    localparam int AreaShift = 13;
    localparam int TwiceW   = 24;
    localparam int NormW    = 16;
    localparam int DefQueueDepth = 4;

    typedef struct packed {
        logic signed [CoordW-1:0] v0_x;
        logic signed [CoordW-1:0] v0_y;
        logic signed [CoordW-1:0] v0_z;
        logic signed [CoordW-1:0] v1_x;
        logic signed [CoordW-1:0] v1_y;
        logic signed [CoordW-1:0] v1_z;
        logic signed [CoordW-1:0] v2_x;
        logic signed [CoordW-1:0] v2_y;
        logic signed [CoordW-1:0] v2_z;
    } tna_in_t;

    typedef struct packed {
        logic signed [NormW-1:0] normal_x;
        logic signed [NormW-1:0] normal_y;
        logic signed [NormW-1:0] normal_z;
        logic [AreaW-1:0]        area;
        logic [TwiceW-1:0]       twice_root_area;
        logic                    degenerate;
    } tna_out_t;

    // one queued item: cross product split as sign and magnitude, plus its squared length
    typedef struct packed {
        logic [2:0]                neg;
        logic [2:0][MagW-1:0]      mag;
        logic [SumW-1:0]           sum;
        logic                      degen;
    } tna_ent_t;

    typedef struct packed {
        logic full;
        logic empty;
    } tna_qstat_t;

    typedef struct packed {
        logic                 valid;
        logic [2:0]           neg;
        logic [2:0][MagW-1:0] mag;
    } tna_aside_t;

    typedef struct packed {
        logic                 valid;
        logic [2:0]           neg;
        logic [2:0][MagW-1:0] mag;
        logic                 degen;
        logic [LenW-1:0]      len;
    } tna_bside_t;

endpackage

// ===== sv/tna_front.sv =====
module tna_front
    import tna_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  tna_in_t  in_data,
    input  logic     q_full,
    output logic     push,
    output tna_ent_t ent
);

    logic                          adv;
    logic [5:0]                    vld_reg, vld_next;
    logic signed [2:0][EdgeW-1:0]  a_reg, a_next, b_reg, b_next;
    logic signed [5:0][ProdW-1:0]  p_reg, p_next;
    logic [2:0]                    neg_c_reg, neg_c_next, neg_q_reg, neg_r_reg, neg_s_reg;
    logic [2:0][MagW-1:0]          mag_c_reg, mag_c_next, mag_q_reg, mag_r_reg, mag_s_reg;
    logic                          dg_c_reg, dg_c_next, dg_q_reg, dg_r_reg, dg_s_reg;
    logic [2:0][2*MagHiW-1:0]      hh_reg, hh_next;
    logic [2:0][MagW-1:0]          hl_reg, hl_next;
    logic [2:0][2*MagLoW-1:0]      ll_reg, ll_next;
    logic [2:0][SumW-1:0]          sq_reg, sq_next;
    logic [SumW-1:0]               sum_reg, sum_next;
    logic signed [ProdW-1:0]       c_w [3];

    assign adv      = !vld_reg[5] || !q_full;
    assign in_ready = adv;
    assign push     = vld_reg[5] && !q_full;
    assign vld_next = {vld_reg[4:0], in_valid};

    always_comb
    begin
        a_next[0] = EdgeW'(in_data.v1_x) - EdgeW'(in_data.v0_x);
        a_next[1] = EdgeW'(in_data.v1_y) - EdgeW'(in_data.v0_y);
        a_next[2] = EdgeW'(in_data.v1_z) - EdgeW'(in_data.v0_z);
        b_next[0] = EdgeW'(in_data.v2_x) - EdgeW'(in_data.v1_x);
        b_next[1] = EdgeW'(in_data.v2_y) - EdgeW'(in_data.v1_y);
        b_next[2] = EdgeW'(in_data.v2_z) - EdgeW'(in_data.v1_z);
        // element selects are unsigned, edges are two's complement
        p_next[0] = $signed(a_reg[1]) * $signed(b_reg[2]);
        p_next[1] = $signed(a_reg[2]) * $signed(b_reg[1]);
        p_next[2] = $signed(a_reg[2]) * $signed(b_reg[0]);
        p_next[3] = $signed(a_reg[0]) * $signed(b_reg[2]);
        p_next[4] = $signed(a_reg[0]) * $signed(b_reg[1]);
        p_next[5] = $signed(a_reg[1]) * $signed(b_reg[0]);
        for (int k = 0; k < 3; k++)
        begin
            c_w[k]        = p_reg[2*k] - p_reg[2*k+1];
            neg_c_next[k] = c_w[k][ProdW-1];
            mag_c_next[k] = c_w[k][ProdW-1] ? MagW'(-c_w[k]) : MagW'(c_w[k]);
            hh_next[k]    = mag_c_reg[k][MagW-1:MagLoW] * mag_c_reg[k][MagW-1:MagLoW];
            hl_next[k]    = mag_c_reg[k][MagW-1:MagLoW] * mag_c_reg[k][MagLoW-1:0];
            ll_next[k]    = mag_c_reg[k][MagLoW-1:0] * mag_c_reg[k][MagLoW-1:0];
            sq_next[k]    = (SumW'(hh_reg[k]) << (2*MagLoW)) + (SumW'(hl_reg[k]) << (MagLoW+1))
                          + SumW'(ll_reg[k]);
        end
        dg_c_next = (c_w[0] == '0) && (c_w[1] == '0) && (c_w[2] == '0);
        sum_next  = sq_reg[0] + sq_reg[1] + sq_reg[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg     <= a_next;
            b_reg     <= b_next;
            p_reg     <= p_next;
            neg_c_reg <= neg_c_next;
            mag_c_reg <= mag_c_next;
            dg_c_reg  <= dg_c_next;
            hh_reg    <= hh_next;
            hl_reg    <= hl_next;
            ll_reg    <= ll_next;
            neg_q_reg <= neg_c_reg;
            mag_q_reg <= mag_c_reg;
            dg_q_reg  <= dg_c_reg;
            sq_reg    <= sq_next;
            neg_r_reg <= neg_q_reg;
            mag_r_reg <= mag_q_reg;
            dg_r_reg  <= dg_q_reg;
            sum_reg   <= sum_next;
            neg_s_reg <= neg_r_reg;
            mag_s_reg <= mag_r_reg;
            dg_s_reg  <= dg_r_reg;
        end
    end

    assign ent.neg   = neg_s_reg;
    assign ent.mag   = mag_s_reg;
    assign ent.sum   = sum_reg;
    assign ent.degen = dg_s_reg;

endmodule

// ===== sv/tna_queue.sv =====
module tna_queue
    import tna_pkg::*;
#(
    parameter int DEPTH = DefQueueDepth
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  tna_ent_t   ent_in,
    input  logic       pop,
    output tna_ent_t   ent_out,
    output tna_qstat_t stat
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    tna_ent_t        mem [DEPTH];
    logic [PW-1:0]   wr_reg, wr_next, rd_reg, rd_next;
    logic [CW-1:0]   cnt_reg, cnt_next;

    assign stat.full  = (cnt_reg == CW'(DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign ent_out    = mem[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
            wr_next = (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        if (pop)
            rd_next = (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= ent_in;
    end

endmodule

// ===== sv/tna_sqrt.sv =====
module tna_sqrt
    import tna_pkg::*;
#(
    parameter int W  = RadW,
    parameter int SW = 1
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic [W-1:0]    rad,
    input  logic [SW-1:0]   side_in,
    output logic [W/2-1:0]  root,
    output logic [SW-1:0]   side_out
);

    localparam int N = W / 2;

    logic [W-1:0]  op_reg   [N];
    logic [W-1:0]  res_reg  [N];
    logic [SW-1:0] side_reg [N];

    // one result bit per stage, classic shift-and-subtract square root
    for (genvar i = 0; i < N; i++)
    begin : g_stage
        localparam int SH = W - 2 - 2 * i;
        logic [W-1:0]  op_in, res_in, one, op_next, res_next;
        logic [SW-1:0] sd_in;
        logic [W:0]    trial;

        if (i == 0)
        begin : g_first
            assign op_in  = rad;
            assign res_in = '0;
            assign sd_in  = side_in;
        end
        else
        begin : g_rest
            assign op_in  = op_reg[i-1];
            assign res_in = res_reg[i-1];
            assign sd_in  = side_reg[i-1];
        end

        assign one = {{(W-1){1'b0}}, 1'b1} << SH;

        always_comb
        begin
            trial = {1'b0, res_in} + {1'b0, one};
            if ({1'b0, op_in} >= trial)
            begin
                op_next  = op_in - trial[W-1:0];
                res_next = (res_in >> 1) + one;
            end
            else
            begin
                op_next  = op_in;
                res_next = res_in >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                side_reg[i] <= '0;
            else if (en)
                side_reg[i] <= sd_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                op_reg[i]  <= op_next;
                res_reg[i] <= res_next;
            end
        end
    end

    assign root     = res_reg[N-1][N-1:0];
    assign side_out = side_reg[N-1];

endmodule

// ===== sv/tna_back.sv =====
module tna_back
    import tna_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     q_valid,
    input  tna_ent_t q_ent,
    output logic     pop,
    output logic     out_valid,
    input  logic     out_ready,
    output tna_out_t out_data
);

    localparam int DS = QuotW;

    logic        en;
    tna_aside_t  a_in, a_out;
    logic        dg_a;
    logic [LenW-1:0]   len_w;
    logic [Root1W-1:0] r1_w;
    tna_bside_t  b_in, b_out;
    logic [Root2W-1:0] r2_w;

    logic                   vld_reg  [DS];
    logic [2:0]             neg_reg  [DS];
    logic                   dg_reg   [DS];
    logic [DivW-1:0]        d_reg    [DS];
    logic [AreaW-1:0]       area_reg [DS];
    logic [TwiceW-1:0]      tw_reg   [DS];
    logic [2:0][NumW-1:0]   rem_reg  [DS];
    logic [2:0][QuotW-1:0]  q_reg    [DS];

    logic     out_valid_reg;
    tna_out_t out_reg, out_next;

    assign en        = !out_valid_reg || out_ready;
    assign pop       = en && q_valid;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign a_in.valid = q_valid;
    assign a_in.neg   = q_ent.neg;
    assign a_in.mag   = q_ent.mag;

    // length of the cross product and the square root of four times its square
    tna_sqrt #(.W(RadW), .SW($bits(tna_aside_t))) u_len (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .rad      ({2'b00, q_ent.sum}),
        .side_in  (a_in),
        .root     (len_w),
        .side_out (a_out)
    );

    tna_sqrt #(.W(RadW), .SW(1)) u_r1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .rad      ({q_ent.sum, 2'b00}),
        .side_in  (q_ent.degen),
        .root     (r1_w),
        .side_out (dg_a)
    );

    assign b_in.valid = a_out.valid;
    assign b_in.neg   = a_out.neg;
    assign b_in.mag   = a_out.mag;
    assign b_in.degen = dg_a;
    assign b_in.len   = len_w;

    tna_sqrt #(.W(Rad2W), .SW($bits(tna_bside_t))) u_r2 (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .rad      (Rad2W'(r1_w)),
        .side_in  (b_in),
        .root     (r2_w),
        .side_out (b_out)
    );

    // restoring division, one quotient bit per stage, three lanes
    for (genvar i = 0; i < DS; i++)
    begin : g_div
        localparam int SH = DS - 1 - i;
        logic                  v_in, dg_in;
        logic [2:0]            n_in;
        logic [DivW-1:0]       d_in;
        logic [AreaW-1:0]      ar_in;
        logic [TwiceW-1:0]     tw_in;
        logic [2:0][NumW-1:0]  rm_in, rm_next;
        logic [2:0][QuotW-1:0] qq_in, qq_next;
        logic [NumW:0]         ds;

        if (i == 0)
        begin : g_first
            logic [Root2W-1:0] len_area;
            assign len_area = Root2W'(b_out.len >> AreaShift);
            assign v_in  = b_out.valid;
            assign dg_in = b_out.degen;
            assign n_in  = b_out.neg;
            assign d_in  = {b_out.len, 1'b0};
            assign ar_in = ((b_out.len >> AreaShift) > LenW'({AreaW{1'b1}}))
                         ? {AreaW{1'b1}} : AreaW'(b_out.len >> AreaShift);
            assign tw_in = (r2_w > Root2W'({TwiceW{1'b1}})) ? {TwiceW{1'b1}}
                         : TwiceW'(r2_w | (len_area & '0));
            for (genvar k = 0; k < 3; k++)
            begin : g_lane
                assign rm_in[k] = {1'b0, b_out.mag[k], {QuotW{1'b0}}} + NumW'(b_out.len);
            end
            assign qq_in = '0;
        end
        else
        begin : g_rest
            assign v_in  = vld_reg[i-1];
            assign dg_in = dg_reg[i-1];
            assign n_in  = neg_reg[i-1];
            assign d_in  = d_reg[i-1];
            assign ar_in = area_reg[i-1];
            assign tw_in = tw_reg[i-1];
            assign rm_in = rem_reg[i-1];
            assign qq_in = q_reg[i-1];
        end

        assign ds = (NumW+1)'(d_in) << SH;

        always_comb
        begin
            rm_next = rm_in;
            qq_next = qq_in;
            for (int k = 0; k < 3; k++)
            begin
                if ({1'b0, rm_in[k]} >= ds)
                begin
                    rm_next[k]     = rm_in[k] - ds[NumW-1:0];
                    qq_next[k][SH] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i] <= 1'b0;
            else if (en)
                vld_reg[i] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dg_reg[i]   <= dg_in;
                neg_reg[i]  <= n_in;
                d_reg[i]    <= d_in;
                area_reg[i] <= ar_in;
                tw_reg[i]   <= tw_in;
                rem_reg[i]  <= rm_next;
                q_reg[i]    <= qq_next;
            end
        end
    end

    always_comb
    begin
        logic signed [2:0][NormW-1:0] nv;
        for (int k = 0; k < 3; k++)
        begin
            if (dg_reg[DS-1])
                nv[k] = '0;
            else if (neg_reg[DS-1][k])
                nv[k] = -NormW'(q_reg[DS-1][k]);
            else
                nv[k] = NormW'(q_reg[DS-1][k]);
        end
        out_next.normal_x        = nv[0];
        out_next.normal_y        = nv[1];
        out_next.normal_z        = nv[2];
        out_next.area            = area_reg[DS-1];
        out_next.twice_root_area = tw_reg[DS-1];
        out_next.degenerate      = dg_reg[DS-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= vld_reg[DS-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= out_next;
    end

endmodule

// ===== sv/triangle_normal_area_core.sv =====
// Triangle unit normal and area.
// Input channel in_valid/in_ready/in_data carries one item: three vertices,
// signed Q11.12. Output channel out_valid/out_ready/out_data returns one item
// per input: unit normal (Q1.14), area (Q20.12), twice the root of the area
// (Q12.12), all saturating, and a degenerate flag for zero-area panels.
// Throughput: one item per cycle while out_ready stays high.
// Pipeline sections, in order from acceptance to out_valid:
//   front pipe (edges, cross product, squares, sum)
//   queue write and read
//   length and sqrt(4S) square roots, bit per stage
//   fourth-root stage chain
//   normal divisions, bit per stage, plus out reg
// The long square-root chain sets the latency; each of its stages is one
// compare-subtract so the rate stays at one item per cycle while out_ready stays high.
// A stalled receiver freezes the back pipe; the front keeps accepting until
// the queue (QUEUE_DEPTH entries) and the front stages fill, then drops
// in_ready. Reset (rst_n, async low) empties all pipes and the queue; no
// setup is needed afterwards.
module triangle_normal_area_core
    import tna_pkg::*;
#(
    parameter int QUEUE_DEPTH = DefQueueDepth
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  tna_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output tna_out_t out_data
);

    logic       push, pop;
    tna_ent_t   ent_f, ent_q;
    tna_qstat_t qstat;

    // front: geometry and squared length, classifies zero-area panels
    tna_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_full   (qstat.full),
        .push     (push),
        .ent      (ent_f)
    );

    // short queue lets the front run on while the back is stalled
    tna_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .ent_in  (ent_f),
        .pop     (pop),
        .ent_out (ent_q),
        .stat    (qstat)
    );

    // back: square roots, normal division, saturation, output register
    tna_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (!qstat.empty),
        .q_ent     (ent_q),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

`ifndef SYNTH
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.degenerate |->
            out_data.normal_x == '0 && out_data.normal_y == '0 &&
            out_data.normal_z == '0 && out_data.area == '0 &&
            out_data.twice_root_area == '0)
        else $error("degenerate item with nonzero fields");

    a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
            out_data.normal_x <= 16'sd16384 && out_data.normal_x >= -16'sd16384 &&
            out_data.normal_y <= 16'sd16384 && out_data.normal_y >= -16'sd16384 &&
            out_data.normal_z <= 16'sd16384 && out_data.normal_z >= -16'sd16384)
        else $error("normal component beyond one");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> qstat.full)
        else $error("input stalled with room in queue");

    a_queue_flags: assert property (@(posedge clk) disable iff (!rst_n)
        !(qstat.full && qstat.empty))
        else $error("queue both full and empty");
`endif

endmodule

// ===== sim/tb.sv =====
module tb
    import tna_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Leave margin after the last item for the pipeline to drain.
    localparam int DrainCycles = 300;
    localparam int StallLimit  = 5000;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    tna_in_t  in_data;
    logic     out_valid;
    logic     out_ready;
    tna_out_t out_data;

    triangle_normal_area_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Expected panels, oldest first.
    tna_out_t panel_q[$];
    int       mismatches;
    int       idle_pct;     // chance in 100 that the sender skips a cycle
    int       stall_pct;    // chance in 100 that the receiver stalls
    int       hold_off;     // cycles of forced receiver stall still to run
    int       quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // floor(sqrt(x)) for x below 2^104
    function automatic logic [63:0] isqrt104(input logic [103:0] x);
        logic [63:0]  r;
        logic [63:0]  cand;
        logic [127:0] sq;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            cand = r | (64'd1 << i);
            sq = cand * cand;
            if (sq <= {24'd0, x})
                r = cand;
        end
        return r;
    endfunction

    // Expected result for one panel.
    function automatic tna_out_t panel_result(input tna_in_t p);
        logic signed [63:0] ax, ay, az, bx, by, bz;
        logic signed [63:0] c[3];
        logic [63:0]        cm[3];
        logic [103:0]       sq_len;
        logic [63:0]        len;
        logic [63:0]        root;
        logic [127:0]       num;
        logic [63:0]        q;
        tna_out_t           r;
        ax = 64'(p.v1_x) - 64'(p.v0_x);
        ay = 64'(p.v1_y) - 64'(p.v0_y);
        az = 64'(p.v1_z) - 64'(p.v0_z);
        bx = 64'(p.v2_x) - 64'(p.v1_x);
        by = 64'(p.v2_y) - 64'(p.v1_y);
        bz = 64'(p.v2_z) - 64'(p.v1_z);
        c[0] = ay * bz - az * by;
        c[1] = az * bx - ax * bz;
        c[2] = ax * by - ay * bx;
        sq_len = '0;
        for (int k = 0; k < 3; k++)
        begin
            cm[k] = c[k] < 0 ? 64'(-c[k]) : 64'(c[k]);
            sq_len += 104'(cm[k]) * 104'(cm[k]);
        end
        r = '0;
        if (sq_len == '0)
        begin
            r.degenerate = 1'b1;
            return r;
        end
        len = isqrt104(sq_len);
        for (int k = 0; k < 3; k++)
        begin
            // round to nearest, halves away from zero
            num = (128'(cm[k]) << 15) + 128'(len);
            q = 64'(num / (128'(len) * 2));
            if (k == 0) r.normal_x = c[k] < 0 ? -16'(q) : 16'(q);
            if (k == 1) r.normal_y = c[k] < 0 ? -16'(q) : 16'(q);
            if (k == 2) r.normal_z = c[k] < 0 ? -16'(q) : 16'(q);
        end
        r.area = (len >> 13) > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : 32'(len >> 13);
        root = isqrt104(sq_len << 2);
        root = isqrt104(104'(root));
        r.twice_root_area = root > 64'hFF_FFFF ? 24'hFF_FFFF : 24'(root);
        return r;
    endfunction

    // Offer one item; hold valid until accepted.
    task automatic send_panel(input tna_in_t p);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= p;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        panel_q.push_back(panel_result(p));
    endtask

    task automatic finish_sending;
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [23:0] rand_coord();
        case ($urandom_range(5))
            0: return 24'h7F_FFFF;
            1: return 24'h80_0000;
            2: return 24'($urandom_range(255)) - 24'd128;
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic tna_in_t rand_panel();
        tna_in_t p;
        p.v0_x = 24'($urandom);
        p.v0_y = 24'($urandom);
        p.v0_z = 24'($urandom);
        p.v1_x = 24'($urandom);
        p.v1_y = 24'($urandom);
        p.v1_z = 24'($urandom);
        p.v2_x = 24'($urandom);
        p.v2_y = 24'($urandom);
        p.v2_z = 24'($urandom);
        case ($urandom_range(9))
            0: p.v1_x = p.v0_x;               // shared x coordinate
            1:
            begin
                p.v1_x = p.v0_x;              // coincident points
                p.v1_y = p.v0_y;
                p.v1_z = p.v0_z;
            end
            default: ;
        endcase
        return p;
    endfunction

    // Receiver: random stalls plus forced hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_off > 0)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (hold_off > 0)
            hold_off <= hold_off - 1;
    end

    // Result checker.
    always @(posedge clk)
    begin
        tna_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (panel_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: %p", out_data);
            end
            else
            begin
                want = panel_q.pop_front();
                if (out_data !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("item mismatch: expected %p actual %p", want, out_data);
                end
            end
        end
    end

    // Watchdog on cycles with no handshake at all.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic run_random(input int n, input int idle, input int stall);
        idle_pct  = idle;
        stall_pct = stall;
        for (int i = 0; i < n; i++)
            send_panel(rand_panel());
        finish_sending();
    endtask

    // Extremes, degenerate panels, axis-aligned normals.
    task automatic test_directed;
        tna_in_t p;
        idle_pct  = 0;
        stall_pct = 0;
        p = '0;
        send_panel(p);                                    // all points equal
        p = '0; p.v1_x = 24'd4096; p.v2_x = 24'd8192;
        send_panel(p);                                    // collinear
        p = '0; p.v1_x = 24'd4096; p.v2_x = 24'd4096; p.v2_y = 24'd4096;
        send_panel(p);                                    // normal +z
        p = '0; p.v1_y = 24'd4096; p.v2_y = 24'd4096; p.v2_z = 24'd4096;
        send_panel(p);                                    // normal +x
        p = '0; p.v1_z = 24'd4096; p.v2_z = 24'd4096; p.v2_x = 24'd4096;
        send_panel(p);                                    // normal +y
        p = '0; p.v1_x = 24'd1; p.v2_x = 24'd1; p.v2_y = 24'd1;
        send_panel(p);                                    // smallest area
        p = '0; p.v1_x = 24'd1; p.v2_y = -24'sd1;
        send_panel(p);                                    // negative normal
        // largest panels: area and root saturate
        p = {24'h80_0000, 24'h80_0000, 24'h80_0000,
             24'h7F_FFFF, 24'h80_0000, 24'h80_0000,
             24'h7F_FFFF, 24'h7F_FFFF, 24'h7F_FFFF};
        send_panel(p);
        p = {24'h7F_FFFF, 24'h7F_FFFF, 24'h7F_FFFF,
             24'h80_0000, 24'h7F_FFFF, 24'h7F_FFFF,
             24'h80_0000, 24'h80_0000, 24'h80_0000};
        send_panel(p);
        p = {24'h80_0000, 24'h7F_FFFF, 24'h80_0000,
             24'h7F_FFFF, 24'h80_0000, 24'h7F_FFFF,
             24'h80_0000, 24'h80_0000, 24'h7F_FFFF};
        send_panel(p);
        for (int i = 0; i < 10; i++)
            send_panel({rand_coord(), rand_coord(), rand_coord(),
                        rand_coord(), rand_coord(), rand_coord(),
                        rand_coord(), rand_coord(), rand_coord()});
        finish_sending();
    endtask

    task automatic test_no_idling;    run_random(500, 0, 0);   endtask
    task automatic test_sender_idle;  run_random(400, 72, 0);  endtask
    task automatic test_recv_stall;   run_random(400, 0, 72);  endtask
    task automatic test_both_idle;    run_random(400, 19, 19); endtask

    // Receiver holds off long enough for the block to fill and drop in_ready.
    task automatic test_backpressure;
        hold_off = 400;
        run_random(200, 0, 0);
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        mismatches   = 0;
        idle_pct     = 0;
        stall_pct    = 0;
        hold_off     = 0;
        quiet_cycles = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_no_idling();
        test_sender_idle();
        test_recv_stall();
        test_both_idle();
        test_backpressure();

        while (panel_q.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
